### hdl/arec_pkg.sv
// ============================================================================
// arec_pkg
// Shared types and constants for the acknowledgement retry controller.
// ============================================================================
package arec_pkg;

    // Field widths.
    localparam int TIME_W      = 32;
    localparam int DELAY_W     = 31;
    localparam int MAX_RETRY_W = 8;
    localparam int RETRY_CNT_W = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Retry counter saturation value.
    localparam logic [RETRY_CNT_W-1:0] RETRY_CNT_MAX = '1;

    // Item opcodes.
    localparam logic OP_POLL = 1'b0;
    localparam logic OP_ACK  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RESEND_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_WAIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES  = 2'd2;

    // Configuration reset values.
    localparam logic [DELAY_W-1:0]     RST_RESEND_DELAY = 31'd1000;
    localparam logic [TIME_W-1:0]      RST_ROUTE_WAIT   = 32'd2000;
    localparam logic [MAX_RETRY_W-1:0] RST_MAX_RETRIES  = 8'd3;

    // Input item.
    typedef struct packed {
        logic              opcode;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic send_data;
        logic send_route_request;
        logic status;
    } t_out_item;

    // Configuration register set.
    typedef struct packed {
        logic [DELAY_W-1:0]     resend_delay_ms;
        logic [TIME_W-1:0]      route_wait_ms;
        logic [MAX_RETRY_W-1:0] max_retries;
    } t_cfg;

endpackage

### hdl/arec_cfg.sv
// ============================================================================
// arec_cfg
// Configuration register file written through a plain write port.
// ============================================================================
module arec_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [arec_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [arec_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output arec_pkg::t_cfg                    o_cfg
);
    import arec_pkg::*;

    t_cfg r_cfg;

    // Register writes keep only the low bits that fit each register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.resend_delay_ms <= RST_RESEND_DELAY;
            r_cfg.route_wait_ms   <= RST_ROUTE_WAIT;
            r_cfg.max_retries     <= RST_MAX_RETRIES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESEND_DELAY: r_cfg.resend_delay_ms <= i_cfg_wdata[DELAY_W-1:0];
                CFG_ROUTE_WAIT:   r_cfg.route_wait_ms   <= i_cfg_wdata[TIME_W-1:0];
                CFG_MAX_RETRIES:  r_cfg.max_retries     <= i_cfg_wdata[MAX_RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/arec_step.sv
// ============================================================================
// arec_step
// Retry state registers and the single-pass poll / acknowledge evaluation.
// ============================================================================
module arec_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  arec_pkg::t_in_item  i_item,
    input  arec_pkg::t_cfg      i_cfg,
    output arec_pkg::t_out_item o_result
);
    import arec_pkg::*;

    logic                   r_active;
    logic                   r_resent;
    logic                   r_rr;
    logic [RETRY_CNT_W-1:0] r_cnt;
    logic [TIME_W-1:0]      r_start;
    logic [TIME_W-1:0]      r_rr_time;

    logic                   n_active;
    logic                   n_resent;
    logic                   n_rr;
    logic [RETRY_CNT_W-1:0] n_cnt;
    logic [TIME_W-1:0]      n_start;
    logic [TIME_W-1:0]      n_rr_time;

    logic [TIME_W-1:0] rr_timeout;
    logic [TIME_W-1:0] resend_delay;
    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] since_rr;
    logic              done;
    t_out_item         result;

    assign rr_timeout   = {i_cfg.resend_delay_ms, 1'b0};
    assign resend_delay = {1'b0, i_cfg.resend_delay_ms};

    // Acknowledge clears the retry state; a poll runs its phases in order on the running state.
    always_comb begin
        n_active    = r_active;
        n_resent    = r_resent;
        n_rr        = r_rr;
        n_cnt       = r_cnt;
        n_start     = r_start;
        n_rr_time   = r_rr_time;
        result      = '0;
        done        = 1'b0;
        since_start = '0;
        since_rr    = '0;

        if (i_item.opcode == OP_ACK) begin
            n_active  = 1'b0;
            n_resent  = 1'b0;
            n_rr      = 1'b0;
            n_cnt     = '0;
            n_start   = '0;
            n_rr_time = '0;
        end else begin
            // Initial send of a new cycle, or drop once retries run out.
            if (!r_active) begin
                if (r_cnt != RETRY_CNT_MAX) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (n_cnt > {1'b0, i_cfg.max_retries}) begin
                    n_active      = 1'b0;
                    n_resent      = 1'b0;
                    n_rr          = 1'b0;
                    n_cnt         = '0;
                    n_start       = '0;
                    n_rr_time     = '0;
                    result.status = 1'b1;
                    done          = 1'b1;
                end else begin
                    n_active         = 1'b1;
                    n_start          = i_item.now_ms;
                    n_rr_time        = '0;
                    n_resent         = 1'b0;
                    n_rr             = 1'b0;
                    result.send_data = 1'b1;
                end
            end

            // Route-request timeout at twice the resend delay.
            since_start = i_item.now_ms - n_start;
            if (!done && !n_rr && since_start >= rr_timeout) begin
                result.send_route_request = 1'b1;
                n_rr      = 1'b1;
                n_rr_time = i_item.now_ms;
                n_resent  = 1'b0;
            end

            // End of the route-request wait closes the cycle.
            since_rr = i_item.now_ms - n_rr_time;
            if (!done && n_rr && since_rr >= i_cfg.route_wait_ms) begin
                n_active  = 1'b0;
                n_start   = '0;
                n_rr_time = '0;
                n_resent  = 1'b0;
                n_rr      = 1'b0;
                done      = 1'b1;
            end

            // Single resend after the resend delay.
            if (!done && !n_resent && !n_rr && since_start >= resend_delay) begin
                result.send_data = 1'b1;
                n_resent         = 1'b1;
            end
        end
    end

    // State commits when an item leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_resent  <= 1'b0;
            r_rr      <= 1'b0;
            r_cnt     <= '0;
            r_start   <= '0;
            r_rr_time <= '0;
        end else if (i_fire) begin
            r_active  <= n_active;
            r_resent  <= n_resent;
            r_rr      <= n_rr;
            r_cnt     <= n_cnt;
            r_start   <= n_start;
            r_rr_time <= n_rr_time;
        end
    end

    assign o_result = result;

endmodule

### hdl/ack_retry_escalation_controller_core.sv
// ============================================================================
// ack_retry_escalation_controller_core
// Acknowledgement retry controller: input register, evaluation, result register.
// ============================================================================
// An accepted input item waits in the input register until the result register
// is free, then its result is written there; one item per cycle unless i_ready
// stalls. The input register, state update and result register form a two-stage
// pipeline; the state is written in the same cycle as the result register.
// Reset (synchronous, active low) clears retry state and both pipeline stages
// and loads the configuration register defaults.
module ack_retry_escalation_controller_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  arec_pkg::t_in_item              i_item,
    output logic                            o_valid,
    input  logic                            i_ready,
    output arec_pkg::t_out_item             o_item,
    input  logic                            i_cfg_we,
    input  logic [arec_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [arec_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import arec_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      advance;
    logic      fire;
    t_cfg      cfg;
    t_out_item result;

    // Stage 2 moves when the result register is empty or being drained.
    assign advance = !r_out_valid || i_ready;
    assign fire    = r_in_valid && advance;
    assign o_ready = !r_in_valid || advance;

    arec_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    arec_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_item <= i_item;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

### hdl/arec_checker.sv
// ============================================================================
// arec_checker
// Port-level checks for the acknowledgement retry controller.
// ============================================================================
module arec_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input arec_pkg::t_out_item o_item
);
    import arec_pkg::*;

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result item changed while stalled");

    // A dropped packet never requests a transmission in the same item.
    a_drop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status |-> !o_item.send_data && !o_item.send_route_request)
        else $error("drop reported together with a send request");

    // The input side only stalls when a result is waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result pending");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind ack_retry_escalation_controller_core arec_checker u_arec_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);
